### rtl/l2d_pkg.sv
`timescale 1ns / 1ps
package l2d_pkg;

	localparam int MAX_ROW_WIDTH = 4096;
	localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
	localparam int WIDTH_W       = COL_W + 1;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'd1;

	typedef enum logic {
		MODE_PREDICT   = 1'b0,
		MODE_UNPREDICT = 1'b1
	} l2d_mode_t;

	// per-sample control decided when the sample is taken
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             first;
		logic             col0;
		logic             last;
	} l2d_ctl_t;

endpackage

### rtl/l2d_if.sv
`timescale 1ns / 1ps
interface l2d_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [32-1:0]     sample;
	logic                     start_frame;

	modport source (output valid, output sample, output start_frame, input ready);
	modport sink   (input valid, input sample, input start_frame, output ready);
endinterface

interface l2d_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [32-1:0]     value;
	logic                     row_end;

	modport source (output valid, output value, output row_end, input ready);
	modport sink   (input valid, input value, input row_end, output ready);
endinterface

### rtl/l2d_line_buf.sv
`timescale 1ns / 1ps
module l2d_line_buf
	import l2d_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [COL_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [COL_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [MAX_ROW_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read during write returns the old entry
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/l2d_seq.sv
`timescale 1ns / 1ps
module l2d_seq
	import l2d_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [WIDTH_W-1:0]   cfg_wdata,
	input  logic                 take,
	input  logic                 start_frame,
	output l2d_ctl_t             ctl,
	output l2d_mode_t            mode
);

	logic [WIDTH_W-1:0] row_width_q;
	l2d_mode_t          mode_q;
	logic [COL_W-1:0]   column_q;
	logic               first_row_q;
	logic [WIDTH_W-1:0] eff_width;
	logic [WIDTH_W-1:0] col_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= WIDTH_W'(MAX_ROW_WIDTH);
			mode_q      <= MODE_PREDICT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROW_WIDTH: row_width_q <= cfg_wdata;
				REG_MODE:      mode_q      <= l2d_mode_t'(cfg_wdata[0]);
				default:       ;
			endcase
		end
	end

	// zero acts as one, oversize clips to the buffer depth
	always_comb begin
		if (row_width_q == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (row_width_q > WIDTH_W'(MAX_ROW_WIDTH)) begin
			eff_width = WIDTH_W'(MAX_ROW_WIDTH);
		end else begin
			eff_width = row_width_q;
		end
	end

	always_comb begin
		ctl.col   = start_frame ? '0 : column_q;
		ctl.first = start_frame ? 1'b1 : first_row_q;
		ctl.col0  = (ctl.col == '0);
		col_next  = {1'b0, ctl.col} + WIDTH_W'(1);
		ctl.last  = (col_next >= eff_width);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (take) begin
			column_q    <= ctl.last ? '0 : col_next[COL_W-1:0];
			first_row_q <= ctl.last ? 1'b0 : ctl.first;
		end
	end

	assign mode = mode_q;

endmodule

### rtl/l2d_dpath.sv
`timescale 1ns / 1ps
module l2d_dpath
	import l2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [DATA_W-1:0] sample,
	input  l2d_ctl_t          ctl,
	input  l2d_mode_t         mode,
	input  logic              out_ready,
	output logic              advance,
	output logic              out_valid,
	output logic [DATA_W-1:0] out_value,
	output logic              out_row_end,
	output logic              buf_we,
	output logic [COL_W-1:0]  buf_waddr,
	output logic [DATA_W-1:0] buf_wdata,
	input  logic [DATA_W-1:0] buf_rdata
);

	logic              v_s1;
	logic [DATA_W-1:0] sample_s1;
	l2d_ctl_t          ctl_s1;
	logic              fwd_hit_s1;
	logic [DATA_W-1:0] fwd_data_s1;

	logic              v_s2;
	logic [DATA_W-1:0] sample_s2;
	l2d_ctl_t          ctl_s2;
	logic [DATA_W-1:0] below_s2;

	logic [DATA_W-1:0] left_q;
	logic [DATA_W-1:0] below_left_q;
	logic              out_v_q;
	logic [DATA_W-1:0] value_q;
	logic              row_end_q;

	logic [DATA_W-1:0] below_sel;
	logic [DATA_W-1:0] pred;
	logic [DATA_W-1:0] orig;
	logic [DATA_W-1:0] res;

	assign advance = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= take;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	// capture the entry being written on the edge the read is issued
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1   <= sample;
			ctl_s1      <= ctl;
			fwd_hit_s1  <= buf_we && (buf_waddr == ctl.col);
			fwd_data_s1 <= buf_wdata;
		end
	end

	// newest writer wins: sample in s2, then the captured write, then the buffer
	always_comb begin
		if (v_s2 && (ctl_s2.col == ctl_s1.col)) begin
			below_sel = orig;
		end else if (fwd_hit_s1) begin
			below_sel = fwd_data_s1;
		end else begin
			below_sel = buf_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			sample_s2 <= sample_s1;
			ctl_s2    <= ctl_s1;
			below_s2  <= below_sel;
		end
	end

	always_comb begin
		if (ctl_s2.first) begin
			pred = ctl_s2.col0 ? '0 : left_q;
		end else if (ctl_s2.col0) begin
			pred = below_s2;
		end else begin
			pred = left_q + below_s2 - below_left_q;
		end
		if (mode == MODE_UNPREDICT) begin
			orig = sample_s2 + pred;
			res  = orig;
		end else begin
			orig = sample_s2;
			res  = sample_s2 - pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			below_left_q <= '0;
		end else if (advance && v_s2) begin
			left_q       <= orig;
			below_left_q <= below_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2) begin
			value_q   <= res;
			row_end_q <= ctl_s2.last;
		end
	end

	assign buf_we      = advance && v_s2;
	assign buf_waddr   = ctl_s2.col;
	assign buf_wdata   = orig;
	assign out_valid   = out_v_q;
	assign out_value   = value_q;
	assign out_row_end = row_end_q;

endmodule

### rtl/lorenzo_2d_predict_unpredict_top.sv
`timescale 1ns / 1ps
// channel   | dir | transfer moves                  | handshake
// ----------+-----+---------------------------------+-------------------------
// samples   | in  | sample (s32), start_frame       | valid/ready
// results   | out | value (s32), row_end            | valid/ready
// cfg       | in  | cfg_idx, cfg_wdata (13 bits)    | cfg_we, no back-pressure
//
// one sample per clock unless results stall; path is s1, s2, output register
// the rate is set by the line buffer: one read at input transfer, one write
// as the sample leaves the compute stage, forwarding covers close rows
// asynchronous active-low reset empties the pipeline; line buffer not cleared
// a stalled result freezes the whole pipeline and holds samples.ready low
module lorenzo_2d_predict_unpredict_top
	import l2d_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	l2d_in_if.sink               samples,
	l2d_out_if.source            results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [WIDTH_W-1:0]   cfg_wdata
);

	logic              take;
	logic              advance;
	l2d_ctl_t          acc_ctl;
	l2d_mode_t         mode;
	logic              buf_we;
	logic [COL_W-1:0]  buf_waddr;
	logic [DATA_W-1:0] buf_wdata;
	logic [DATA_W-1:0] buf_rdata;
	logic [DATA_W-1:0] out_value;

	// a sample is taken when it is valid and the output side can move
	assign samples.ready = advance;
	assign take          = samples.valid && advance;

	// column counter, bottom-row flag and configuration registers
	l2d_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.take        (take),
		.start_frame (samples.start_frame),
		.ctl         (acc_ctl),
		.mode        (mode)
	);

	// previous row of originals, read at transfer time
	l2d_line_buf u_line_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (take),
		.raddr (acc_ctl.col),
		.rdata (buf_rdata)
	);

	// forwarding stage, prediction stage and output register
	l2d_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sample      (samples.sample),
		.ctl         (acc_ctl),
		.mode        (mode),
		.out_ready   (results.ready),
		.advance     (advance),
		.out_valid   (results.valid),
		.out_value   (out_value),
		.out_row_end (results.row_end),
		.buf_we      (buf_we),
		.buf_waddr   (buf_waddr),
		.buf_wdata   (buf_wdata),
		.buf_rdata   (buf_rdata)
	);

	assign results.value = out_value;

	// input side only moves when the output register can be refilled
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready == (!results.valid || results.ready))
		else $error("input ready does not follow output side");

	// a frame start always lands on column zero of the bottom row
	a_frame_start_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		(take && samples.start_frame) |-> (acc_ctl.col0 && acc_ctl.first))
		else $error("frame start not at bottom row, column zero");

	// every line buffer write comes with a result in the next cycle
	a_write_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		buf_we |=> results.valid)
		else $error("line buffer written without a result");

endmodule
